@@ sv/scmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command message parser package
// Shared constants, command codes and the result record of the parser.
// ----------------------------------------------------------------------------
package scmp_pkg;

	localparam int MSG_CAPACITY_DEF = 127;

	localparam int RX_WIDTH    = 8;
	localparam int LEN_WIDTH   = 7;
	localparam int CMD_WIDTH   = 5;
	localparam int PER_WIDTH   = 9;
	localparam int OUT_BYTES_W = 40;

	localparam logic [CMD_WIDTH-1:0] CMD_IDLE       = 5'd0;
	localparam logic [CMD_WIDTH-1:0] CMD_SKIP_NEXT  = 5'd1;
	localparam logic [CMD_WIDTH-1:0] CMD_SET_PERIOD = 5'd2;
	localparam logic [CMD_WIDTH-1:0] CMD_ERASE      = 5'd3;
	localparam logic [CMD_WIDTH-1:0] CMD_SAVE       = 5'd4;

	localparam logic [RX_WIDTH-1:0]  FIRST_PRINTABLE = 8'd32;
	localparam logic [RX_WIDTH-1:0]  MIN_SPEED_BYTE  = 8'h50;
	localparam logic [RX_WIDTH-1:0]  PLUS_CHAR       = 8'h2B;
	localparam logic [PER_WIDTH-1:0] PERIOD_RESET    = 9'd407;

	typedef struct packed {
		logic                 message_done;
		logic                 overflow;
		logic                 save_request;
		logic                 erase_request;
		logic                 store_valid;
		logic [LEN_WIDTH-1:0] store_index;
		logic [RX_WIDTH-1:0]  store_data;
		logic [LEN_WIDTH-1:0] length_now;
		logic [PER_WIDTH-1:0] period_now;
		logic                 saving_on;
		logic                 in_message;
	} scmp_result_t;

endpackage

@@ sv/scmp_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parser state and next-state logic
// Holds the command, message and setting state and computes one result per
// byte; the state advances when a byte is stepped through.
// ----------------------------------------------------------------------------
module scmp_parse #(
	parameter int MSG_CAPACITY = scmp_pkg::MSG_CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic [scmp_pkg::RX_WIDTH-1:0]        rx_byte,
	output scmp_pkg::scmp_result_t               result
);
	import scmp_pkg::*;

	localparam int                   CapInt = (MSG_CAPACITY > 127) ? 127 : MSG_CAPACITY;
	localparam logic [LEN_WIDTH-1:0] CapEff = LEN_WIDTH'(CapInt);

	logic [CMD_WIDTH-1:0] pending_q, pending_d;
	logic                 reading_q, reading_d;
	logic [LEN_WIDTH-1:0] length_q, length_d;
	logic [PER_WIDTH-1:0] period_q, period_d;
	logic                 saving_q, saving_d;

	always_comb begin
		logic                 do_append;
		logic [RX_WIDTH-1:0]  speed_v;
		do_append = 1'b0;
		speed_v   = '0;
		pending_d = pending_q;
		reading_d = reading_q;
		length_d  = length_q;
		period_d  = period_q;
		saving_d  = saving_q;
		result    = '0;

		priority if (reading_q) begin
			do_append = 1'b1;
		end else if (pending_q == CMD_IDLE) begin
			priority if (rx_byte == PLUS_CHAR) begin
				pending_d = CMD_SKIP_NEXT;
			end else if (rx_byte == {3'b000, CMD_ERASE}) begin
				result.erase_request = 1'b1;
			end else if (rx_byte < FIRST_PRINTABLE) begin
				pending_d = rx_byte[CMD_WIDTH-1:0];
			end else begin
				length_d  = '0;
				reading_d = 1'b1;
				do_append = 1'b1;
			end
		end else begin
			if (pending_q == CMD_SET_PERIOD && rx_byte != '0) begin
				speed_v  = (rx_byte < MIN_SPEED_BYTE) ? MIN_SPEED_BYTE : rx_byte;
				period_d = {speed_v, 1'b0};
			end else if (pending_q == CMD_SAVE && rx_byte != '0) begin
				saving_d = (rx_byte == 8'd1);
			end
			pending_d = CMD_IDLE;
		end

		if (do_append) begin
			if (rx_byte < FIRST_PRINTABLE) begin
				pending_d = CMD_IDLE;
				reading_d = 1'b0;
				result.save_request = saving_q && (length_d != '0);
				result.message_done = 1'b1;
			end else begin
				if (length_d < CapEff) begin
					result.store_valid = 1'b1;
					result.store_index = length_d;
					result.store_data  = rx_byte;
					length_d           = length_d + 1'b1;
				end
				if (length_d == CapEff) begin
					pending_d           = CMD_SKIP_NEXT;
					result.overflow     = 1'b1;
					result.message_done = 1'b1;
				end
			end
		end

		result.length_now = length_d;
		result.period_now = period_d;
		result.saving_on  = saving_d;
		result.in_message = reading_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= CMD_IDLE;
			reading_q <= 1'b0;
			length_q  <= '0;
			period_q  <= PERIOD_RESET;
			saving_q  <= 1'b0;
		end else if (step) begin
			pending_q <= pending_d;
			reading_q <= reading_d;
			length_q  <= length_d;
			period_q  <= period_d;
			saving_q  <= saving_d;
		end
	end

endmodule

@@ sv/serial_command_message_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial command message parser
// Turns received serial bytes into commands, settings and message text.
// ----------------------------------------------------------------------------
// Each received byte yields exactly one result. A byte is held in an input
// register, parsed combinationally and its result placed in an output
// register, so one byte per clock is sustained while the output is not
// stalled; the result is presented from the output register. Stalls on the
// result side hold the output register and push back on the input side.
module serial_command_message_parser #(
	parameter int MSG_CAPACITY = scmp_pkg::MSG_CAPACITY_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// rx_byte[7:0]
	input  logic [scmp_pkg::RX_WIDTH-1:0]        s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// overflow[0], save_request[1], erase_request[2], store_valid[3],
	// store_index[10:4], store_data[18:11], length_now[25:19],
	// period_now[34:26], saving_on[35], in_message[36], zero fill above.
	output logic [scmp_pkg::OUT_BYTES_W-1:0]     m_tdata,
	// message_done
	output logic                                 m_tlast
);
	import scmp_pkg::*;

	logic                valid_s1;
	logic [RX_WIDTH-1:0] byte_s1;
	logic                valid_s2;
	scmp_result_t        result_s2;
	scmp_result_t        result_c;
	logic                out_free;
	logic                advance;

	assign out_free = !valid_s2 || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	scmp_parse #(
		.MSG_CAPACITY(MSG_CAPACITY)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.rx_byte(byte_s1),
		.result (result_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tlast  = result_s2.message_done;
	assign m_tdata  = {3'b000,
		result_s2.in_message,
		result_s2.saving_on,
		result_s2.period_now,
		result_s2.length_now,
		result_s2.store_data,
		result_s2.store_index,
		result_s2.store_valid,
		result_s2.erase_request,
		result_s2.save_request,
		result_s2.overflow};

endmodule
